>>> rtl/core/price_time_order_matcher_macros.svh
// Assertion helpers for the order matcher.
`ifndef PRICE_TIME_ORDER_MATCHER_MACROS_SVH
`define PRICE_TIME_ORDER_MATCHER_MACROS_SVH

`define PTOM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PTOM_NEVER(label, expr, msg) \
  `PTOM_ASSERT(label, !(expr), msg)

`endif

>>> rtl/core/ptom_pkg.sv
package ptom_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_MATCH  = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

endpackage

>>> rtl/core/ptom_compare.sv
module ptom_compare
  import ptom_pkg::*;
(
  input  logic              want_side,
  input  logic              best_found,
  input  logic [FieldW-1:0] cand_price,
  input  logic [FieldW-1:0] best_price,
  input  logic [FieldW-1:0] cand_age,
  input  logic [FieldW-1:0] best_age,
  output logic              take
);

  logic better_price;
  logic same_price;

  always_comb begin
    better_price = (want_side == SIDE_BUY) ? (cand_price > best_price)
                                           : (cand_price < best_price);
    same_price   = (cand_price == best_price);
    take         = !best_found || better_price || (same_price && (cand_age > best_age));
  end

endmodule

>>> rtl/core/price_time_order_matcher.sv
// Price-time priority limit order book matcher.
// Input channel in_*: one order per transfer; tdata holds order_id, limit_price,
// order_volume from the lowest bit up, tuser holds cmd, side from bit 0.
// Output channel out_*: result records; tdata holds taker_id, resting_id, fill_volume,
// fill_price, remaining_volume from the lowest bit up, tuser = kind, tlast marks the
// last record of an item.
// An insert finds the first free slot; its record is offered the cycle
// after acceptance, and the next input is accepted the cycle after that record transfers.
// A match runs one scan per fill: the shared compare unit visits one slot per cycle.
// A scan visits every slot and then decides; a fill offers its record and passes through
// ST_EMIT before the next scan starts. After the last fill the done record follows a
// closing scan, which is skipped when the order is used up.
// in_tready is high only when the block is idle; one item is worked at a time.
// When the receiver stalls, the pending record holds in the output register; the sequencer
// keeps scanning and waits only when it has the next record to offer.
// Reset empties the store, zeroes the arrival counter and drops any record.
module price_time_order_matcher
  import ptom_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // order_id, limit_price, order_volume
  input  logic [1:0]   in_tuser,   // cmd, side
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // taker_id, resting_id, fill_volume, fill_price, remaining_volume
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast
);

  localparam int unsigned IdxW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ORDER_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_FILL, ST_EMIT, ST_DONE
  } state_t;

  state_t            state_r;
  logic [ORDER_SLOTS-1:0] valid_r;
  logic              side_mem [ORDER_SLOTS];
  logic [FieldW-1:0] price_mem [ORDER_SLOTS];
  logic [FieldW-1:0] vol_mem [ORDER_SLOTS];
  logic [FieldW-1:0] owner_mem [ORDER_SLOTS];
  logic [FieldW-1:0] arr_mem [ORDER_SLOTS];
  logic [FieldW-1:0] arrival_r;

  logic              side_r;
  logic [FieldW-1:0] id_r, limit_r, vol_r;
  logic [CntW-1:0]   scan_r;
  logic [CntW-1:0]   iter_r;
  logic              found_r;
  logic [IdxW-1:0]   best_r;
  logic [FieldW-1:0] bprice_r, bage_r;

  logic              ov_r, olast_r;
  kind_t             okind_r;
  logic [FieldW-1:0] orest_r, ofvol_r, ofprice_r, oremain_r;

  logic [IdxW-1:0]   cidx;
  logic              cand_ok, take;
  logic [FieldW-1:0] cage;
  logic              free_found;
  logic [IdxW-1:0]   free_idx;
  logic [FieldW-1:0] used;
  logic              price_ok;

  assign cidx    = scan_r[IdxW-1:0];
  assign cage    = arrival_r - arr_mem[cidx];
  assign cand_ok = valid_r[cidx] && (side_mem[cidx] == !side_r);

  ptom_compare u_cmp (
    .want_side  (!side_r),
    .best_found (found_r),
    .cand_price (price_mem[cidx]),
    .best_price (bprice_r),
    .cand_age   (cage),
    .best_age   (bage_r),
    .take       (take)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
    used     = (vol_mem[best_r] < vol_r) ? vol_mem[best_r] : vol_r;
    price_ok = (side_r == SIDE_BUY) ? (bprice_r <= limit_r) : (bprice_r >= limit_r);
  end

  assign in_tready  = (state_r == ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {oremain_r, ofprice_r, ofvol_r, orest_r, id_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      arrival_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            side_r  <= in_tuser[1];
            id_r    <= in_tdata[31:0];
            limit_r <= in_tdata[63:32];
            vol_r   <= in_tdata[95:64];
            orest_r <= '0; ofvol_r <= '0; ofprice_r <= '0;
            oremain_r <= in_tdata[95:64];
            olast_r <= 1'b1;
            iter_r  <= '0;
            scan_r  <= '0;
            found_r <= 1'b0;
            if (in_tuser[0] == CMD_MATCH) begin
              state_r <= ST_SCAN;
            end else begin
              ov_r <= 1'b1;
              if (in_tdata[95:64] == '0) begin
                okind_r <= KIND_DONE;
              end else if (!free_found) begin
                okind_r <= KIND_REJECT;
              end else begin
                okind_r <= KIND_DONE;
                valid_r[free_idx]   <= 1'b1;
                side_mem[free_idx]  <= in_tuser[1];
                price_mem[free_idx] <= in_tdata[63:32];
                vol_mem[free_idx]   <= in_tdata[95:64];
                owner_mem[free_idx] <= in_tdata[31:0];
                arr_mem[free_idx]   <= arrival_r;
                arrival_r <= arrival_r + 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (vol_r == '0 || iter_r == CntW'(ORDER_SLOTS)) begin
            state_r <= ST_DONE;
          end else if (scan_r == CntW'(ORDER_SLOTS)) begin
            state_r <= (found_r && price_ok) ? ST_FILL : ST_DONE;
          end else begin
            if (cand_ok && take) begin
              found_r  <= 1'b1;
              best_r   <= cidx;
              bprice_r <= price_mem[cidx];
              bage_r   <= cage;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_FILL: begin
          if (!ov_r) begin
            ov_r      <= 1'b1;
            okind_r   <= KIND_FILL;
            orest_r   <= owner_mem[best_r];
            ofvol_r   <= used;
            ofprice_r <= bprice_r;
            oremain_r <= vol_r - used;
            olast_r   <= 1'b0;
            vol_r     <= vol_r - used;
            vol_mem[best_r] <= vol_mem[best_r] - used;
            if (vol_mem[best_r] == used) valid_r[best_r] <= 1'b0;
            iter_r  <= iter_r + 1'b1;
            scan_r  <= '0;
            found_r <= 1'b0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          state_r <= ST_SCAN;
        end
        ST_DONE: begin
          if (!ov_r) begin
            ov_r      <= 1'b1;
            okind_r   <= KIND_DONE;
            orest_r   <= '0; ofvol_r <= '0; ofprice_r <= '0;
            oremain_r <= vol_r;
            olast_r   <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ptom_checker.sv
`include "price_time_order_matcher_macros.svh"
module ptom_checker
  import ptom_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  `PTOM_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled record changed")
  `PTOM_ASSERT(a_busy, in_tvalid && in_tready |=> !in_tready, "ready right after a transfer")
  `PTOM_NEVER(a_fill_last, out_tvalid && out_tuser == KIND_FILL && out_tlast, "fill marked last")
  `PTOM_NEVER(a_nonfill_not_last, out_tvalid && out_tuser != KIND_FILL && !out_tlast, "record not last")
  `PTOM_NEVER(a_ready_busy, in_tready && out_tvalid, "ready while record pending")

endmodule

bind price_time_order_matcher ptom_checker u_ptom_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
